// ----- rtl/core/bcm_pkg.sv -----
package bcm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_MIN    = 3;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH_MODE   = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  localparam logic [PIX_W-1:0] PIX_EMPTY = 8'd0;
  localparam logic [PIX_W-1:0] PIX_FULL  = 8'd255;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] pix;
    logic             inner;
    logic             mode;
  } win_t;

endpackage

// ----- rtl/core/bcm_line_store.sv -----
module bcm_line_store #(
  parameter int DEPTH = bcm_pkg::MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr_above,
  input  logic [AW-1:0]              rd_addr_two,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bcm_pkg::PIX_W-1:0]  wr_above,
  input  logic [bcm_pkg::PIX_W-1:0]  wr_two,
  output logic [bcm_pkg::PIX_W-1:0]  rd_above,
  output logic [bcm_pkg::PIX_W-1:0]  rd_two
);

  logic [bcm_pkg::PIX_W-1:0] above_mem [DEPTH];
  logic [bcm_pkg::PIX_W-1:0] two_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr] <= wr_above;
    end
    if (rd_en) begin
      rd_above <= above_mem[rd_addr_above];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      two_mem[wr_addr] <= wr_two;
    end
    if (rd_en) begin
      rd_two <= two_mem[rd_addr_two];
    end
  end

endmodule

// ----- rtl/core/bcm_kernel.sv -----
module bcm_kernel (
  input  bcm_pkg::win_t              win,
  output logic [bcm_pkg::PIX_W-1:0]  val
);

  logic all_zero;
  logic all_full;

  always_comb begin
    all_zero = (win.mid == bcm_pkg::PIX_EMPTY) && (win.left == bcm_pkg::PIX_EMPTY) &&
               (win.right == bcm_pkg::PIX_EMPTY) && (win.up == bcm_pkg::PIX_EMPTY) &&
               (win.pix == bcm_pkg::PIX_EMPTY);
    all_full = (win.mid == bcm_pkg::PIX_FULL) && (win.left == bcm_pkg::PIX_FULL) &&
               (win.right == bcm_pkg::PIX_FULL) && (win.up == bcm_pkg::PIX_FULL) &&
               (win.pix == bcm_pkg::PIX_FULL);
    if (!win.inner) begin
      val = win.mid;
    end else if (win.mode == bcm_pkg::MODE_ERODE) begin
      val = all_full ? bcm_pkg::PIX_FULL : bcm_pkg::PIX_EMPTY;
    end else begin
      val = all_zero ? bcm_pkg::PIX_EMPTY : bcm_pkg::PIX_FULL;
    end
  end

endmodule

// ----- rtl/core/bcm_out_queue.sv -----
module bcm_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  bcm_pkg::res_t  push_item0,
  input  bcm_pkg::res_t  push_item1,
  output logic           room2,
  output logic           out_valid,
  output bcm_pkg::res_t  out_item,
  input  logic           out_ready
);

  localparam int QAW = bcm_pkg::QAW;

  bcm_pkg::res_t  q_mem [bcm_pkg::QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign out_item  = q_mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= (QAW+1)'(bcm_pkg::QDEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
    count_nxt  = count_r + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_mem[wr_ptr_r] <= push_item0;
    end
    if (push_cnt == 2'd2) begin
      q_mem[wr_ptr_r + QAW'(1)] <= push_item1;
    end
  end

  a_pair_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |-> (count_r <= (QAW+1)'(bcm_pkg::QDEPTH - 2)))
    else $error("result pair pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= (QAW+1)'(bcm_pkg::QDEPTH)))
    else $error("queue count above depth");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && push_cnt == 2'd0) |=> (count_r == '0))
    else $error("queue filled without a push");

endmodule

// ----- rtl/core/binary_cross_morphology_core.sv -----
// A pixel accepted on the input is registered in stage 1, then pushed into the output
//   queue, which drives out_tdata.
// Throughput: one pixel per cycle while the output queue has room for two results; in the
//   last row of a frame each pixel yields two results, which leave the port one per cycle.
// Line stores are synchronous RAMs, read one pixel ahead and written back when stage 1
//   advances.
// Reset (rst_n, synchronous): position, pipeline, queue and registers go to defaults;
//   line store contents are not cleared.
module binary_cross_morphology_core #(
  parameter int MAX_WIDTH  = bcm_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = bcm_pkg::MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bcm_pkg::IN_TDATA_W-1:0]      in_tdata,   // pixel_in
  input  logic                                in_tuser,   // frame_start
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bcm_pkg::OUT_TDATA_W-1:0]     out_tdata,  // pixel_out, out_row, out_col
  output logic                                out_tlast,  // run_last
  input  logic                                cfg_we,
  input  logic [bcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PAD_W = bcm_pkg::OUT_TDATA_W - bcm_pkg::PIX_W - bcm_pkg::ROW_W - bcm_pkg::COL_W;

  logic [bcm_pkg::WIDTH_REG_W-1:0]  cfg_width_r, cfg_width_nxt;
  logic [bcm_pkg::HEIGHT_REG_W-1:0] cfg_height_r, cfg_height_nxt;
  logic                             cfg_mode_r, cfg_mode_nxt;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          in_acc;
  logic          pos_reset;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic          last_col;
  logic          last_row;
  logic [CW-1:0] rd_addr_above;

  logic                      s1_valid_r, s1_valid_nxt;
  logic [bcm_pkg::PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]             s1_col_r;
  logic [RW-1:0]             s1_row_r;
  logic                      s1_emit_a_r;
  logic                      s1_emit_b_r;
  logic                      s1_inner_r;
  logic                      s1_adv;

  logic [bcm_pkg::PIX_W-1:0] mid_r;
  logic [bcm_pkg::PIX_W-1:0] left_r;
  logic [bcm_pkg::PIX_W-1:0] rd_above;
  logic [bcm_pkg::PIX_W-1:0] rd_two;

  bcm_pkg::win_t             win;
  logic [bcm_pkg::PIX_W-1:0] kern_val;
  bcm_pkg::res_t             res_a, res_b, item0, q_item;
  logic [1:0]                push_cnt;
  logic                      room2;

  // configuration
  always_comb begin
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    cfg_mode_nxt   = cfg_mode_r;
    if (cfg_we) begin
      case (cfg_index)
        bcm_pkg::REG_IMAGE_WIDTH:  cfg_width_nxt  = cfg_data[bcm_pkg::WIDTH_REG_W-1:0];
        bcm_pkg::REG_IMAGE_HEIGHT: cfg_height_nxt = cfg_data[bcm_pkg::HEIGHT_REG_W-1:0];
        bcm_pkg::REG_MORPH_MODE:   cfg_mode_nxt   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(cfg_width_r) < bcm_pkg::DIM_MIN) begin
      w_eff = WW'(bcm_pkg::DIM_MIN);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    if (32'(cfg_height_r) < bcm_pkg::DIM_MIN) begin
      h_eff = HW'(bcm_pkg::DIM_MIN);
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height_r);
    end
  end

  // position and read issue
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    pos_reset = in_tuser || (WW'(col_r) >= w_eff) || (HW'(row_r) >= h_eff);
    c_cur     = pos_reset ? '0 : col_r;
    r_cur     = pos_reset ? '0 : row_r;
    last_col  = ((WW'(c_cur) + WW'(1)) == w_eff);
    last_row  = ((HW'(r_cur) + HW'(1)) == h_eff);
    // read the right neighbour, or column 0 of this row for the next row's start
    rd_addr_above = last_col ? '0 : c_cur + CW'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : r_cur + RW'(1);
      end else begin
        col_nxt = c_cur + CW'(1);
        row_nxt = r_cur;
      end
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= bcm_pkg::WIDTH_RESET;
      cfg_height_r <= bcm_pkg::HEIGHT_RESET;
      cfg_mode_r   <= bcm_pkg::MODE_DILATE;
      col_r        <= '0;
      row_r        <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
      cfg_mode_r   <= cfg_mode_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r    <= in_tdata[bcm_pkg::PIX_W-1:0];
      s1_col_r    <= c_cur;
      s1_row_r    <= r_cur;
      s1_emit_a_r <= (r_cur != '0);
      s1_emit_b_r <= last_row;
      s1_inner_r  <= (r_cur >= RW'(2)) && (c_cur != '0) && !last_col;
    end
    if (s1_adv) begin
      mid_r  <= rd_above;
      left_r <= mid_r;
    end
  end

  bcm_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk           (clk),
    .rd_en         (in_acc),
    .rd_addr_above (rd_addr_above),
    .rd_addr_two   (c_cur),
    .wr_en         (s1_adv),
    .wr_addr       (s1_col_r),
    .wr_above      (s1_pix_r),
    .wr_two        (mid_r),
    .rd_above      (rd_above),
    .rd_two        (rd_two)
  );

  // stage 1: window and results
  assign s1_adv = s1_valid_r && room2;

  always_comb begin
    win.mid   = mid_r;
    win.left  = left_r;
    win.right = rd_above;
    win.up    = rd_two;
    win.pix   = s1_pix_r;
    win.inner = s1_inner_r;
    win.mode  = cfg_mode_r;
  end

  bcm_kernel u_kernel (
    .win (win),
    .val (kern_val)
  );

  always_comb begin
    res_a.pix  = kern_val;
    res_a.row  = bcm_pkg::ROW_W'(s1_row_r - RW'(1));
    res_a.col  = bcm_pkg::COL_W'(s1_col_r);
    res_a.last = !s1_emit_b_r;
    res_b.pix  = s1_pix_r;
    res_b.row  = bcm_pkg::ROW_W'(s1_row_r);
    res_b.col  = bcm_pkg::COL_W'(s1_col_r);
    res_b.last = 1'b1;
    item0      = s1_emit_a_r ? res_a : res_b;
    push_cnt   = s1_adv ? ({1'b0, s1_emit_a_r} + {1'b0, s1_emit_b_r}) : 2'd0;
  end

  bcm_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_item0 (item0),
    .push_item1 (res_b),
    .room2      (room2),
    .out_valid  (out_tvalid),
    .out_item   (q_item),
    .out_ready  (out_tready)
  );

  assign out_tdata = {{PAD_W{1'b0}}, q_item.col, q_item.row, q_item.pix};
  assign out_tlast = q_item.last;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_pix_r)))
    else $error("stage 1 transaction lost while stalled");

endmodule
